/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* hw/rtl/utf8d_pkg.sv */
// Types and constants for the UTF-8 validating decoder.
package utf8d_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_OVERLONG_LEAD = 3'd1,
      STATUS_LEAD_RANGE    = 3'd2,
      STATUS_STRAY_CONT    = 3'd3,
      STATUS_BAD_CONT      = 3'd4,
      STATUS_OVERLONG_2ND  = 3'd5,
      STATUS_SURROGATE     = 3'd6,
      STATUS_TRUNCATED     = 3'd7
   } status_type;

   // Byte boundaries of the well-formed table
   localparam logic [7:0] ASCII_MAX     = 8'h7F;
   localparam logic [7:0] CONT_MIN      = 8'h80;
   localparam logic [7:0] CONT_MAX      = 8'hBF;
   localparam logic [7:0] LEAD2_MIN     = 8'hC2;
   localparam logic [7:0] LEAD2_MAX     = 8'hDF;
   localparam logic [7:0] LEAD_E0       = 8'hE0;
   localparam logic [7:0] LEAD_ED       = 8'hED;
   localparam logic [7:0] LEAD3_MAX     = 8'hEF;
   localparam logic [7:0] LEAD_F0       = 8'hF0;
   localparam logic [7:0] LEAD_F4       = 8'hF4;
   localparam logic [7:0] CONT_A0       = 8'hA0;
   localparam logic [7:0] CONT_9F       = 8'h9F;
   localparam logic [7:0] CONT_90       = 8'h90;
   localparam logic [7:0] CONT_8F       = 8'h8F;

   // Open-sequence state
   typedef struct packed {
      logic [7:0]  lead_value;
      logic [1:0]  bytes_remaining;
      logic [14:0] partial_value;
      logic [1:0]  bytes_taken;
   } state_type;

   // One result word
   typedef struct packed {
      logic [20:0] code_point;
      status_type  status;
      logic [2:0]  sequence_length;
      logic [7:0]  offending_byte;
   } result_type;

endpackage

/* hw/rtl/utf8d_channels.sv */
// Valid/ready channel interfaces for decoder input bytes and result words.
interface utf8d_req_if import utf8d_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8d_rsp_if import utf8d_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  status;
   logic [2:0]  sequence_length;
   logic [7:0]  offending_byte;

   modport source (output valid, output code_point, output status,
                   output sequence_length, output offending_byte, input ready);
   modport sink   (input valid, input code_point, input status,
                   input sequence_length, input offending_byte, output ready);
endinterface

/* hw/rtl/utf8d_step.sv */
// Per-byte decode: checks one byte against the open sequence and forms the next state.
module utf8d_step import utf8d_pkg::*; (
   input  state_type  state,
   input  logic [7:0] data_byte,
   input  logic       end_of_text,
   output state_type  state_next,
   output logic       emit,
   output result_type result
);

   logic [2:0]  len;
   logic [7:0]  lo;
   logic [7:0]  hi;
   logic [20:0] acc;

   assign len = {1'b0, state.bytes_taken} + 3'd1;
   assign acc = {state.partial_value, data_byte[5:0]};

   // Allowed continuation window; narrowed on the second byte for special leads
   always_comb begin
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (state.bytes_taken == 2'd1) begin
         case (state.lead_value)
            LEAD_E0: lo = CONT_A0;
            LEAD_ED: hi = CONT_9F;
            LEAD_F0: lo = CONT_90;
            LEAD_F4: hi = CONT_8F;
            default: ;
         endcase
      end
   end

   // Decode and state update
   always_comb begin
      state_next = state;
      emit       = 1'b0;
      result     = '{code_point: '0, status: STATUS_OK, sequence_length: 3'd1,
                     offending_byte: data_byte};

      if (state.bytes_remaining == 2'd0) begin
         // idle: expect a lead byte
         if (data_byte <= ASCII_MAX) begin
            emit = 1'b1;
            result.code_point = {13'd0, data_byte};
         end else if (data_byte <= CONT_MAX) begin
            emit = 1'b1;
            result.status = STATUS_STRAY_CONT;
         end else if (data_byte < LEAD2_MIN) begin
            emit = 1'b1;
            result.status = STATUS_OVERLONG_LEAD;
         end else if (data_byte > LEAD_F4) begin
            emit = 1'b1;
            result.status = STATUS_LEAD_RANGE;
         end else begin
            state_next.lead_value  = data_byte;
            state_next.bytes_taken = 2'd1;
            if (data_byte <= LEAD2_MAX) begin
               state_next.bytes_remaining = 2'd1;
               state_next.partial_value   = {10'd0, data_byte[4:0]};
            end else if (data_byte <= LEAD3_MAX) begin
               state_next.bytes_remaining = 2'd2;
               state_next.partial_value   = {11'd0, data_byte[3:0]};
            end else begin
               state_next.bytes_remaining = 2'd3;
               state_next.partial_value   = {12'd0, data_byte[2:0]};
            end
            if (end_of_text) begin
               emit = 1'b1;
               result.status = STATUS_TRUNCATED;
            end
         end
      end else begin
         // continuation position
         result.sequence_length = len;
         if (state.bytes_taken == 2'd1 && state.lead_value == LEAD_E0 &&
             data_byte >= CONT_MIN && data_byte < CONT_A0) begin
            emit = 1'b1;
            result.status = STATUS_OVERLONG_2ND;
         end else if (state.bytes_taken == 2'd1 && state.lead_value == LEAD_ED &&
                      data_byte > CONT_9F && data_byte <= CONT_MAX) begin
            emit = 1'b1;
            result.status = STATUS_SURROGATE;
         end else if (state.bytes_taken == 2'd1 && state.lead_value == LEAD_F0 &&
                      data_byte >= CONT_MIN && data_byte < CONT_90) begin
            emit = 1'b1;
            result.status = STATUS_OVERLONG_2ND;
         end else if (data_byte < lo || data_byte > hi) begin
            emit = 1'b1;
            result.status = STATUS_BAD_CONT;
         end else if (state.bytes_remaining == 2'd1) begin
            emit = 1'b1;
            result.code_point = acc;
         end else begin
            state_next.partial_value   = acc[14:0];
            state_next.bytes_remaining = state.bytes_remaining - 2'd1;
            state_next.bytes_taken     = len[1:0];
            if (end_of_text) begin
               emit = 1'b1;
               result.status = STATUS_TRUNCATED;
            end
         end
      end

      // any result closes the sequence
      if (emit) begin
         state_next = '0;
      end
   end

endmodule

/* hw/rtl/utf8_validating_decoder_top.sv */
// Top level of the UTF-8 validating decoder: input register, byte decode, result register.
// One byte word is taken per cycle while the result side keeps taking words, and at most
// one result word leaves per byte. A byte lands in the input register, is decoded against
// the open sequence from there, and its result (if any) then goes to the result register.
// A stalled result side keeps the byte in the input register until the result moves on.
// A complete sequence, a faulty byte, or a byte marked end-of-text that leaves continuation
// bytes owed yields a result; code_point is zero unless status is ok.
// After any result the decoder is idle and expects a lead byte.
`include "assert_macros.svh"

module utf8_validating_decoder_top import utf8d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   state_type  state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       advance;
   logic       process;
   logic       req_fire;
   logic       emit;
   result_type result;

   // Handshake control
   assign advance   = !out_valid_ff || rsp_bus.ready;
   assign process   = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire  = req_bus.valid && req_bus.ready;

   utf8d_step u_step (
      .state       (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .state_next  (state_in),
      .emit        (emit),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = process && emit;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.end_of_text;
      end
      if (process && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.code_point      = out_ff.code_point;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.sequence_length = out_ff.sequence_length;
   assign rsp_bus.offending_byte  = out_ff.offending_byte;

   // Error results never carry a code point
   `ASSERT_ALWAYS(a_err_zero_cp, clock, reset,
      !out_valid_ff || out_ff.status == STATUS_OK || out_ff.code_point == 21'd0)
   // Length stays within one to four bytes
   `ASSERT_ALWAYS(a_len_range, clock, reset,
      !out_valid_ff || (out_ff.sequence_length != 3'd0 && out_ff.sequence_length <= 3'd4))
   // An open sequence has taken at least its lead
   `ASSERT_ALWAYS(a_open_taken, clock, reset,
      state_ff.bytes_remaining == 2'd0 || state_ff.bytes_taken != 2'd0)
   // Every result returns the decoder to idle
   `ASSERT_NEXT(a_emit_idle, clock, reset, process && emit,
      state_ff.bytes_remaining == 2'd0 && out_valid_ff)

endmodule
